// File: sv/laplacian_edge_threshold_filter_defines.svh
// ----------------------------------------------------------------------------
// Laplacian edge filter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_EDGE_THRESHOLD_FILTER_DEFINES_SVH
`define LAPLACIAN_EDGE_THRESHOLD_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LETF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LETF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/letf_pkg.sv
// ----------------------------------------------------------------------------
// Laplacian edge filter package
// Shared constants and the window bundle passed from the line buffer to the
// filter kernel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package letf_pkg;

  // Pixel and configuration port sizes.
  localparam int PIX_W        = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int THR_W        = 9;
  localparam int ROW_W        = 12;
  localparam int HEIGHT_LIMIT = 4096;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [THR_W-1:0]      THRESH_RST = 9'd1;

  // Neighborhood and result flags for one accepted pixel.
  typedef struct packed {
    logic [PIX_W-1:0] north;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] west;
    logic [PIX_W-1:0] east;
    logic [PIX_W-1:0] south;
    logic             interior;
    logic             emit_main;
    logic             main_last;
    logic             emit_bottom;
    logic             frame_end;
  } tap_t;

endpackage

// File: sv/letf_ram.sv
// ----------------------------------------------------------------------------
// Generic line RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module letf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while the read is not enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: sv/letf_window.sv
// ----------------------------------------------------------------------------
// Laplacian edge filter line buffer
// Tracks the raster position, keeps the two previous rows in one RAM with a
// one-column read-ahead, and registers the 3x3 cross window of each pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "laplacian_edge_threshold_filter_defines.svh"

module letf_window #(
  parameter int MAX_WIDTH = 4096,
  parameter int CHANNELS  = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_write_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  w_m1_i,
  input  logic [letf_pkg::ROW_W-1:0]    h_m1_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [letf_pkg::PIX_W-1:0]    pixel_in_i,
  input  logic                          adv_i,
  output logic                          s1_valid_o,
  output letf_pkg::tap_t                s1_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int DW = CHANNELS * 8;
  localparam int SW = 2 * DW;

  // Prefetch sequencer codes.
  localparam logic [1:0] ST_FETCH_A = 2'd0;
  localparam logic [1:0] ST_FETCH_B = 2'd1;
  localparam logic [1:0] ST_RUN     = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic [CW-1:0]              col_q;
  logic [letf_pkg::ROW_W-1:0] row_q;
  logic [SW-1:0]              cur_q;
  logic [DW-1:0]              prev_above_q;
  logic                       s1_valid_q;
  letf_pkg::tap_t             s1_q, tap_d;

  logic [CW-1:0]              c_eff, c_succ, c_succ2;
  logic [letf_pkg::ROW_W-1:0] r_eff;
  logic                       last_col, last_row, accept;
  logic                       ram_re;
  logic [CW-1:0]              ram_raddr;
  logic [SW-1:0]              ram_rd;

  // Position clamped to the current image size, and the next two columns.
  assign c_eff    = (col_q > w_m1_i) ? w_m1_i : col_q;
  assign r_eff    = (row_q > h_m1_i) ? h_m1_i : row_q;
  assign last_col = (c_eff == w_m1_i);
  assign last_row = (r_eff == h_m1_i);
  assign c_succ   = last_col ? '0 : c_eff + CW'(1);

  always_comb begin
    if (last_col) begin
      c_succ2 = CW'(1);
    end else if (c_eff + CW'(1) == w_m1_i) begin
      c_succ2 = '0;
    end else begin
      c_succ2 = c_eff + CW'(2);
    end
  end

  assign in_ready_o = (state_q == ST_RUN) && (!s1_valid_q || adv_i);
  assign accept     = in_valid_i && in_ready_o;

  // Read-ahead: after reset or a register write the current and next columns
  // are fetched; in normal running each transaction fetches two columns on.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FETCH_A: begin
        ram_re    = 1'b1;
        ram_raddr = c_eff;
        state_d   = ST_FETCH_B;
      end
      ST_FETCH_B: begin
        ram_re    = 1'b1;
        ram_raddr = c_succ;
        state_d   = ST_RUN;
      end
      ST_RUN: begin
        ram_re    = accept;
        ram_raddr = c_succ2;
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = c_eff;
        state_d   = ST_FETCH_A;
      end
    endcase
    if (cfg_write_i) begin
      state_d = ST_FETCH_A;
    end
  end

  // Each entry holds the row two above in the upper half and the row above in
  // the lower half.
  letf_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (c_eff),
    .wdata_i ({cur_q[DW-1:0], pixel_in_i[DW-1:0]}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rd)
  );

  // Window and result flags for the pixel being accepted.
  always_comb begin
    tap_d             = '0;
    tap_d.north       = letf_pkg::PIX_W'(cur_q[SW-1:DW]);
    tap_d.centre      = letf_pkg::PIX_W'(cur_q[DW-1:0]);
    tap_d.west        = letf_pkg::PIX_W'(prev_above_q);
    tap_d.east        = last_col ? '0 : letf_pkg::PIX_W'(ram_rd[DW-1:0]);
    tap_d.south       = letf_pkg::PIX_W'(pixel_in_i[DW-1:0]);
    tap_d.interior    = (r_eff >= letf_pkg::ROW_W'(2)) && (c_eff != '0) && !last_col;
    tap_d.emit_main   = (r_eff != '0);
    tap_d.main_last   = !last_row;
    tap_d.emit_bottom = last_row;
    tap_d.frame_end   = last_col;
  end

  // Sequencer, position counters and window registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FETCH_A;
      col_q        <= '0;
      row_q        <= '0;
      prev_above_q <= '0;
      s1_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        prev_above_q <= cur_q[DW-1:0];
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : r_eff + letf_pkg::ROW_W'(1);
        end else begin
          col_q <= c_eff + CW'(1);
          row_q <= r_eff;
        end
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FETCH_B) || accept) begin
      cur_q <= ram_rd;
    end
    if (accept) begin
      s1_q <= tap_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

  `LETF_ASSERT_NXT(a_accept_fills_stage, accept, s1_valid_q)
  `LETF_ASSERT_NXT(a_frame_wraps, accept && last_col && last_row, col_q == '0 && row_q == '0)
  `LETF_ASSERT_NXT(a_stage_holds, s1_valid_q && !adv_i, s1_valid_q && $stable(s1_q.south))

endmodule

// File: sv/letf_out.sv
// ----------------------------------------------------------------------------
// Laplacian edge filter kernel and result stage
// Computes the thresholded four-neighbor Laplacian per channel and holds up
// to two results per input pixel for the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "laplacian_edge_threshold_filter_defines.svh"

module letf_out #(
  parameter int CHANNELS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s1_valid_i,
  input  letf_pkg::tap_t              s1_i,
  output logic                        adv_o,
  input  logic [letf_pkg::THR_W-1:0]  threshold_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [letf_pkg::PIX_W-1:0]  pixel_out_o,
  output logic                        last_of_run_o,
  output logic                        end_of_frame_o
);

  logic                       v0_q, v1_q;
  logic [letf_pkg::PIX_W-1:0] p0_q;
  logic                       last0_q, eof1_q;
  logic [letf_pkg::PIX_W-1:0] lap;
  logic                       free, load, take;

  // Per channel: (4*centre - north - south - west - east) / 2, truncated
  // toward zero, low byte kept, then zeroed below the threshold.
  always_comb begin
    logic signed [10:0] v;
    logic signed [10:0] q;
    logic [7:0]         b;
    lap = '0;
    v   = '0;
    q   = '0;
    b   = '0;
    for (int z = 0; z < CHANNELS; z++) begin
      v = $signed({1'b0, s1_i.centre[8*z +: 8], 2'b00})
        - $signed({3'b000, s1_i.north[8*z +: 8]})
        - $signed({3'b000, s1_i.south[8*z +: 8]})
        - $signed({3'b000, s1_i.west[8*z +: 8]})
        - $signed({3'b000, s1_i.east[8*z +: 8]});
      q = (v + $signed({10'b0, v[10]})) >>> 1;
      b = q[7:0];
      if ({1'b0, b} < threshold_i) begin
        b = '0;
      end
      lap[8*z +: 8] = b;
    end
  end

  // The stage can take a new window when it is empty or its last result
  // transaction completes this cycle.
  assign free        = !(v0_q || v1_q) || (out_ready_i && (v0_q ^ v1_q));
  assign adv_o       = free;
  assign load        = s1_valid_i && free;
  assign out_valid_o = v0_q || v1_q;
  assign take        = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (load) begin
      v0_q <= s1_i.emit_main;
      v1_q <= s1_i.emit_bottom;
    end else if (take) begin
      if (v0_q) begin
        v0_q <= 1'b0;
      end else begin
        v1_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      p0_q    <= s1_i.interior ? lap : '0;
      last0_q <= s1_i.main_last;
      eof1_q  <= s1_i.frame_end;
    end
  end

  // The row result goes first; the bottom-row result is always zero.
  assign pixel_out_o    = v0_q ? p0_q : '0;
  assign last_of_run_o  = v0_q ? last0_q : 1'b1;
  assign end_of_frame_o = v0_q ? 1'b0 : eof1_q;

  `LETF_ASSERT_NXT(a_pair_drains, take && v0_q && v1_q, v1_q && !v0_q)
  `LETF_ASSERT_NOW(a_eof_ends_run, out_valid_o && end_of_frame_o, last_of_run_o)
  `LETF_ASSERT_NXT(a_load_shows, load && (s1_i.emit_main || s1_i.emit_bottom), out_valid_o)

endmodule

// File: sv/laplacian_edge_threshold_filter.sv
// ----------------------------------------------------------------------------
// Laplacian edge threshold filter
// Streaming four-neighbor Laplacian edge filter on RGBA pixels in raster
// order, with one threshold shared by all channels and a one-row output lag.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the in_valid_i/in_ready_o channel in raster order. Each
//   input pixel of row r (r >= 1) produces the filtered pixel of row r-1;
//   pixels of the last row also produce the zero bottom-row pixel after it.
//   Border pixels come out as zero. last_of_run_o marks the final result of
//   an input transaction, end_of_frame_o the last pixel of the image.
//   The cfg channel writes image_width (0), image_height (1) and threshold
//   (2); it is always ready and should be used only while the block is idle.
//   A result is registered in the window stage and then in the output stage
//   before it is presented, and either stage holds it while output stalls.
//   Throughput: one pixel per cycle while the receiver takes every result,
//   set by the line RAM read-ahead, which issues one read per pixel; pixels
//   of the last row give two results each, so there the output holds back input.
//   After reset and after each configuration write the line RAM read-ahead
//   fetches two columns before in_ready_o rises. Line contents are not cleared.
//   When the receiver stalls, results wait in the output stage and one more
//   pixel is held in the window register before in_ready_o drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module laplacian_edge_threshold_filter #(
  parameter int MAX_WIDTH = 4096,
  parameter int CHANNELS  = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [letf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [letf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [letf_pkg::PIX_W-1:0]       pixel_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [letf_pkg::PIX_W-1:0]       pixel_out_o,
  output logic                             last_of_run_o,
  output logic                             end_of_frame_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [letf_pkg::CFG_DATA_W-1:0] width_q, height_q;
  logic [letf_pkg::THR_W-1:0]      thresh_q;
  logic                            cfg_write;
  logic [CW-1:0]                   w_m1;
  logic [letf_pkg::ROW_W-1:0]      h_m1;
  logic                            s1_valid, adv;
  letf_pkg::tap_t                  s1;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= letf_pkg::WIDTH_RST;
      height_q <= letf_pkg::HEIGHT_RST;
      thresh_q <= letf_pkg::THRESH_RST;
    end else if (cfg_write) begin
      case (cfg_index_i)
        letf_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
        letf_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        letf_pkg::CFG_THRESH: thresh_q <= cfg_data_i[letf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Image size saturated to the supported range, as last index.
  always_comb begin
    if (width_q < letf_pkg::CFG_DATA_W'(3)) begin
      w_m1 = CW'(2);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(width_q - letf_pkg::CFG_DATA_W'(1));
    end
    if (height_q < letf_pkg::CFG_DATA_W'(3)) begin
      h_m1 = letf_pkg::ROW_W'(2);
    end else if (height_q > letf_pkg::CFG_DATA_W'(letf_pkg::HEIGHT_LIMIT)) begin
      h_m1 = letf_pkg::ROW_W'(letf_pkg::HEIGHT_LIMIT - 1);
    end else begin
      h_m1 = letf_pkg::ROW_W'(height_q - letf_pkg::CFG_DATA_W'(1));
    end
  end

  letf_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .CHANNELS  (CHANNELS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_write),
    .w_m1_i      (w_m1),
    .h_m1_i      (h_m1),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_in_i  (pixel_in_i),
    .adv_i       (adv),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1)
  );

  letf_out #(
    .CHANNELS (CHANNELS)
  ) u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s1_valid_i     (s1_valid),
    .s1_i           (s1),
    .adv_o          (adv),
    .threshold_i    (thresh_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_out_o    (pixel_out_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule
